// File: design/bsas_pkg.sv
// Shared types and constants for the signed BCD add, subtract and shift block.
`timescale 1ns / 1ps

package bsas_pkg;

  localparam int MAG_W      = 64;
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 4;
  localparam int MAX_DIGITS = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_SHL = 2'd2,
    OP_SHR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_POS_OVF = 2'd1,
    ST_NEG_OVF = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic                 a_sign;
    logic [MAG_W-1:0]     a_magnitude;
    logic                 b_sign;
    logic [MAG_W-1:0]     b_magnitude;
    logic [CNT_W-1:0]     shift_count;
  } in_word_t;

  typedef struct packed {
    logic                 result_sign;
    logic [MAG_W-1:0]     result_magnitude;
    logic [LEN_W-1:0]     result_length;
    status_t              status;
  } res_word_t;

endpackage

// File: design/bsas_if.sv
// Valid/ready channel interfaces for operation words and result words.
`timescale 1ns / 1ps

interface bsas_in_if;
  import bsas_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               a_sign;
  logic [MAG_W-1:0]   a_magnitude;
  logic               b_sign;
  logic [MAG_W-1:0]   b_magnitude;
  logic [CNT_W-1:0]   shift_count;

  modport source (
    output valid, opcode, a_sign, a_magnitude, b_sign, b_magnitude, shift_count,
    input  ready
  );

  modport sink (
    input  valid, opcode, a_sign, a_magnitude, b_sign, b_magnitude, shift_count,
    output ready
  );
endinterface

interface bsas_out_if;
  import bsas_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_sign;
  logic [MAG_W-1:0]   result_magnitude;
  logic [LEN_W-1:0]   result_length;
  logic [1:0]         status;

  modport source (
    output valid, result_sign, result_magnitude, result_length, status,
    input  ready
  );

  modport sink (
    input  valid, result_sign, result_magnitude, result_length, status,
    output ready
  );
endinterface

// File: design/bcd_signed_add_sub_shift_top.sv
// Top level of the signed BCD add, subtract and shift block.
// Path: an accepted word is held in the input register, goes through the combinational
// ALU and is loaded into the result register, which drives the output handshake.
// Throughput: one word per cycle unless the output stalls; input and result registers form
// a two-entry pipeline; input is taken while a result waits if the input register is free.
// Reset: synchronous, active low; clears both valid flags, no payload reset.
`timescale 1ns / 1ps

module bcd_signed_add_sub_shift_top #(
  parameter int DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bsas_in_if.sink     in_ch,
  bsas_out_if.source  out_ch
);
  import bsas_pkg::*;

  in_word_t   in_word;
  in_word_t   s1_word_r;
  logic       s1_valid_r;
  res_word_t  alu_res;
  res_word_t  out_word_r;
  logic       out_valid_r;
  logic       adv;
  logic       in_ready;
  logic       in_fire;

  assign in_word.opcode      = opcode_t'(in_ch.opcode);
  assign in_word.a_sign      = in_ch.a_sign;
  assign in_word.a_magnitude = in_ch.a_magnitude;
  assign in_word.b_sign      = in_ch.b_sign;
  assign in_word.b_magnitude = in_ch.b_magnitude;
  assign in_word.shift_count = in_ch.shift_count;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ready    = !s1_valid_r || adv;
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  bsas_alu #(
    .DIGITS (DIGITS)
  ) u_alu (
    .in_word  (s1_word_r),
    .res_word (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_ch.valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_word_r <= in_word;
    if (adv && s1_valid_r) out_word_r <= alu_res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_sign      = out_word_r.result_sign;
  assign out_ch.result_magnitude = out_word_r.result_magnitude;
  assign out_ch.result_length    = out_word_r.result_length;
  assign out_ch.status           = out_word_r.status;

  a_err_clears : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.status != ST_OK) |->
      (out_word_r.result_magnitude == '0) && !out_word_r.result_sign &&
      (out_word_r.result_length == LEN_W'(1)))
    else $error("error result carries nonzero payload");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline is full");

  a_fire_loads : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word lost from input register");

  a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.result_length >= LEN_W'(1)) &&
      (out_word_r.result_length <= LEN_W'(DIGITS)))
    else $error("result length out of range");

endmodule

// File: design/bsas_alu.sv
// Combinational decimal add, subtract and digit shift on sign-magnitude BCD words.
`timescale 1ns / 1ps

module bsas_alu #(
  parameter int DIGITS = 16
) (
  input  bsas_pkg::in_word_t  in_word,
  output bsas_pkg::res_word_t res_word
);
  import bsas_pkg::*;

  localparam int W = 4 * DIGITS;

  function automatic logic [W-1:0] clean(input logic [W-1:0] x);
    logic [W-1:0] r;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = (x[4*i +: 4] > 4'd9) ? 4'd9 : x[4*i +: 4];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] nines(input logic [W-1:0] x);
    logic [W-1:0] r;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = 4'd9 - x[4*i +: 4];
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] len_of(input logic [W-1:0] x);
    logic [LEN_W-1:0] len;
    len = LEN_W'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (x[4*i +: 4] != 4'd0) len = LEN_W'(i + 1);
    end
    return len;
  endfunction

  // Decimal add with digit carries resolved by one binary carry chain.
  function automatic logic [W:0] bcd_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                         input logic cin);
    logic [4:0]        raw [DIGITS];
    logic [DIGITS-1:0] g;
    logic [DIGITS-1:0] t;
    logic [DIGITS:0]   csum;
    logic [DIGITS:0]   c;
    logic [4:0]        fix;
    logic [W-1:0]      s;
    for (int i = 0; i < DIGITS; i++) begin
      raw[i] = {1'b0, x[4*i +: 4]} + {1'b0, y[4*i +: 4]};
      g[i]   = raw[i] > 5'd9;
      t[i]   = raw[i] >= 5'd9;
    end
    csum = {1'b0, t} + {1'b0, g} + {{DIGITS{1'b0}}, cin};
    c    = csum ^ {1'b0, t} ^ {1'b0, g};
    for (int i = 0; i < DIGITS; i++) begin
      fix = raw[i] + {4'd0, c[i]};
      if (fix > 5'd9) fix = fix + 5'd6;
      s[4*i +: 4] = fix[3:0];
    end
    return {c[DIGITS], s};
  endfunction

  logic [W-1:0]       a;
  logic [W-1:0]       b;
  logic               ea;
  logic               eb;
  logic [W:0]         s_ab;
  logic [W:0]         d_ab;
  logic [W:0]         d_ba;
  logic [LEN_W-1:0]   len_a;
  logic [5:0]         sh_amt;
  logic [W-1:0]       up;
  logic [W-1:0]       dn;
  logic               up_bad;
  logic               dn_bad;
  logic [W-1:0]       mag;
  logic               sgn;
  status_t            st;

  assign a      = clean(in_word.a_magnitude[W-1:0]);
  assign b      = clean(in_word.b_magnitude[W-1:0]);
  assign ea     = in_word.a_sign;
  assign eb     = in_word.b_sign ^ (in_word.opcode == OP_SUB);
  assign s_ab   = bcd_add(a, b, 1'b0);
  assign d_ab   = bcd_add(a, nines(b), 1'b1);
  assign d_ba   = bcd_add(b, nines(a), 1'b1);
  assign len_a  = len_of(a);
  assign sh_amt = {in_word.shift_count, 2'b00};
  assign up     = a << sh_amt;
  assign dn     = a >> sh_amt;
  assign up_bad = ({1'b0, len_a} + {2'b00, in_word.shift_count}) > 6'(DIGITS - 1);
  assign dn_bad = {1'b0, in_word.shift_count} >= len_a;

  always_comb begin
    mag = '0;
    sgn = 1'b0;
    st  = ST_OK;
    unique case (in_word.opcode) inside
      OP_ADD, OP_SUB: begin
        if (ea == eb) begin
          if (s_ab[W]) begin
            st = ea ? ST_NEG_OVF : ST_POS_OVF;
          end else begin
            mag = s_ab[W-1:0];
            sgn = ea;
          end
        end else if (d_ab[W]) begin
          mag = d_ab[W-1:0];
          sgn = ea;
        end else begin
          mag = d_ba[W-1:0];
          sgn = eb;
        end
        sgn = sgn & (mag != '0);
      end
      OP_SHL: begin
        if (up_bad) begin
          st = ST_RANGE;
        end else begin
          mag = up;
          sgn = ea;
        end
      end
      OP_SHR: begin
        if (dn_bad) begin
          st = ST_RANGE;
        end else begin
          mag = dn;
          sgn = ea;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign res_word.result_sign      = sgn;
  assign res_word.result_magnitude = MAG_W'(mag);
  assign res_word.result_length    = len_of(mag);
  assign res_word.status           = st;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the signed BCD add, subtract and shift block.
`timescale 1ns / 1ps

module tb;
  import bsas_pkg::*;

  localparam int DIGITS      = 16;
  localparam int N_RANDOM    = 1700;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_EDGES = 8;
  localparam logic [63:0] NINES = {16{4'h9}};

  typedef struct {
    in_word_t  w;
    bit        typed;
    res_word_t r;
  } stim_row_t;

  localparam int N_DIRECTED = 24;

  stim_row_t dir_rows [N_DIRECTED] = '{
    '{'{OP_ADD, 1'b0, 64'h0, 1'b0, 64'h0, 4'd0}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_OK}},
    '{'{OP_ADD, 1'b1, 64'h0, 1'b1, 64'h0, 4'd5}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_OK}},
    '{'{OP_ADD, 1'b0, NINES, 1'b0, 64'h1, 4'd0}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_POS_OVF}},
    '{'{OP_ADD, 1'b1, NINES, 1'b1, 64'h1, 4'd0}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_NEG_OVF}},
    '{'{OP_SUB, 1'b0, 64'h0, 1'b0, NINES, 4'd0}, 1'b1, '{1'b1, NINES, 5'd16, ST_OK}},
    '{'{OP_SUB, 1'b1, NINES, 1'b0, NINES, 4'd0}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_NEG_OVF}},
    '{'{OP_ADD, 1'b0, NINES, 1'b1, NINES, 4'd0}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_OK}},
    '{'{OP_ADD, 1'b0, '1, 1'b0, 64'h0, 4'd0}, 1'b1, '{1'b0, NINES, 5'd16, ST_OK}},
    '{'{OP_ADD, 1'b0, 64'h5, 1'b0, 64'h7, 4'd0}, 1'b1, '{1'b0, 64'h12, 5'd2, ST_OK}},
    '{'{OP_SUB, 1'b0, 64'h3, 1'b0, 64'h8, 4'd0}, 1'b1, '{1'b1, 64'h5, 5'd1, ST_OK}},
    '{'{OP_SHL, 1'b0, 64'h1, 1'b0, 64'h0, 4'd14}, 1'b1,
      '{1'b0, 64'h0100_0000_0000_0000, 5'd15, ST_OK}},
    '{'{OP_SHL, 1'b0, 64'h1, 1'b0, 64'h0, 4'd15}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_RANGE}},
    '{'{OP_SHL, 1'b1, 64'h0, 1'b0, 64'h0, 4'd3}, 1'b1, '{1'b1, 64'h0, 5'd1, ST_OK}},
    '{'{OP_SHR, 1'b0, 64'h123, 1'b1, NINES, 4'd2}, 1'b1, '{1'b0, 64'h1, 5'd1, ST_OK}},
    '{'{OP_SHR, 1'b0, 64'h123, 1'b0, 64'h0, 4'd3}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_RANGE}},
    '{'{OP_SHR, 1'b1, 64'h0, 1'b0, 64'h0, 4'd0}, 1'b1, '{1'b1, 64'h0, 5'd1, ST_OK}},
    '{'{OP_SHL, 1'b0, NINES, 1'b0, 64'h0, 4'd0}, 1'b1, '{1'b0, 64'h0, 5'd1, ST_RANGE}},
    '{'{OP_SHR, 1'b1, '1, 1'b1, '1, 4'd15}, 1'b0, '0},
    '{'{OP_ADD, 1'b1, {16{4'hA}}, 1'b0, {16{4'h5}}, 4'd9}, 1'b0, '0},
    '{'{OP_SUB, 1'b1, 64'h1234_5678_9012_3456, 1'b1, 64'h0987_6543_2109_8765, 4'd7},
      1'b0, '0},
    '{'{OP_ADD, 1'b0, 64'h5000_0000_0000_0000, 1'b0, 64'h5000_0000_0000_0000, 4'd0},
      1'b0, '0},
    '{'{OP_SUB, 1'b0, 64'h0, 1'b1, 64'h0, 4'd1}, 1'b0, '0},
    '{'{OP_SHL, 1'b1, 64'h12, 1'b1, 64'h0, 4'd13}, 1'b0, '0},
    '{'{OP_ADD, 1'b1, 64'h1, 1'b0, 64'h1, 4'd15}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  bsas_in_if  in_if ();
  bsas_out_if out_if ();

  bcd_signed_add_sub_shift_top #(.DIGITS(DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  res_word_t pending_results [$];
  res_word_t want_res;
  int        mismatches = 0;
  int        words_sent = 0;
  bit        feeding_done = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] clamp_digits(logic [63:0] m);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = (m[4*i +: 4] > 4'd9) ? 4'd9 : m[4*i +: 4];
    end
    return r;
  endfunction

  function automatic longint bcd_to_num(logic [63:0] m);
    longint v;
    v = 0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      v = v * 10 + longint'(m[4*i +: 4]);
    end
    return v;
  endfunction

  function automatic logic [63:0] num_to_bcd(longint v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  function automatic logic [4:0] digit_count(logic [63:0] m);
    logic [4:0] n;
    n = 5'd1;
    for (int i = 0; i < DIGITS; i++) begin
      if (m[4*i +: 4] != 4'd0) n = 5'(i + 1);
    end
    return n;
  endfunction

  function automatic res_word_t predict_result(in_word_t w);
    res_word_t   r;
    logic [63:0] am;
    logic [63:0] bm;
    longint      lim;
    longint      va;
    longint      vb;
    longint      s;
    bit          b_neg;
    int          len;
    r = '0;
    r.status = ST_OK;
    am = clamp_digits(w.a_magnitude);
    bm = clamp_digits(w.b_magnitude);
    case (w.opcode) inside
      OP_ADD, OP_SUB: begin
        lim = 1;
        for (int i = 0; i < DIGITS; i++) lim = lim * 10;
        b_neg = (w.opcode == OP_SUB) ? !w.b_sign : w.b_sign;
        va = w.a_sign ? -bcd_to_num(am) : bcd_to_num(am);
        vb = b_neg ? -bcd_to_num(bm) : bcd_to_num(bm);
        s = va + vb;
        if (s >= lim) begin
          r.status = ST_POS_OVF;
        end else if (s <= -lim) begin
          r.status = ST_NEG_OVF;
        end else if (s < 0) begin
          r.result_sign = 1'b1;
          r.result_magnitude = num_to_bcd(-s);
        end else begin
          r.result_magnitude = num_to_bcd(s);
        end
      end
      OP_SHL: begin
        len = int'(digit_count(am));
        if (len + int'(w.shift_count) > DIGITS - 1) r.status = ST_RANGE;
        else r.result_magnitude = am << (4 * w.shift_count);
      end
      default: begin
        len = int'(digit_count(am));
        if (int'(w.shift_count) >= len) r.status = ST_RANGE;
        else r.result_magnitude = am >> (4 * w.shift_count);
      end
    endcase
    if ((w.opcode == OP_SHL || w.opcode == OP_SHR) && r.status == ST_OK) begin
      r.result_sign = w.a_sign;
    end
    r.result_length = digit_count(r.result_magnitude);
    return r;
  endfunction

  function automatic logic [63:0] rand_mag();
    logic [63:0] m;
    int          len;
    m = '0;
    case ($urandom_range(0, 11))
      0: m = {$urandom, $urandom};
      1: m = NINES;
      2: m = '0;
      default: begin
        len = $urandom_range(1, DIGITS);
        for (int i = 0; i < len; i++) m[4*i +: 4] = 4'($urandom_range(0, 9));
      end
    endcase
    return m;
  endfunction

  function automatic in_word_t make_word();
    in_word_t w;
    w.opcode      = opcode_t'($urandom_range(0, 3));
    w.a_sign      = 1'($urandom_range(0, 1));
    w.a_magnitude = rand_mag();
    w.b_sign      = 1'($urandom_range(0, 1));
    w.b_magnitude = ($urandom_range(0, 7) == 0) ? w.a_magnitude : rand_mag();
    w.shift_count = 4'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_run();
    if ($urandom_range(0, 9) == 0) return $urandom_range(50, 150);
    return $urandom_range(1, 8);
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch %0t: %s want %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  task automatic send_word(in_word_t w, bit typed, res_word_t r, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= w.opcode;
    in_if.a_sign      <= w.a_sign;
    in_if.a_magnitude <= w.a_magnitude;
    in_if.b_sign      <= w.b_sign;
    in_if.b_magnitude <= w.b_magnitude;
    in_if.shift_count <= w.shift_count;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_results.push_back(typed ? r : predict_result(w));
    words_sent++;
  endtask

  initial begin : feed_words
    int gap;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= '0;
    in_if.a_sign      <= 1'b0;
    in_if.a_magnitude <= '0;
    in_if.b_sign      <= 1'b0;
    in_if.b_magnitude <= '0;
    in_if.shift_count <= '0;
    do @(posedge clk); while (rst_n !== 1'b1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r, pick_gap());
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      gap = ((n % 100) < 30) ? 0 : pick_gap();
      send_word(make_word(), 1'b0, '0, gap);
    end
    in_if.valid <= 1'b0;
    feeding_done = 1'b1;
  end

  // random ready gaps, plus one long hold-off so the pipeline fills and stalls its input
  initial begin : pace_sink
    int  n;
    bit  held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!held && words_sent >= 400) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat (pick_run()) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word, magnitude", '0, out_if.result_magnitude);
      end else begin
        want_res = pending_results.pop_front();
        if (out_if.result_sign !== want_res.result_sign)
          note_mismatch("result_sign", 64'(want_res.result_sign),
                        64'(out_if.result_sign));
        if (out_if.result_magnitude !== want_res.result_magnitude)
          note_mismatch("result_magnitude", want_res.result_magnitude,
                        out_if.result_magnitude);
        if (out_if.result_length !== want_res.result_length)
          note_mismatch("result_length", 64'(want_res.result_length),
                        64'(out_if.result_length));
        if (out_if.status !== want_res.status)
          note_mismatch("status", 64'(want_res.status), 64'(out_if.status));
      end
    end
  end

  initial begin : run_control
    int idle;
    idle = 0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!(feeding_done && pending_results.size() == 0) && idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) idle = 0;
      else idle++;
    end
    if (idle >= STALL_LIMIT) begin
      $display("tb failed");
    end else begin
      repeat (DRAIN_EDGES) @(posedge clk);
      if (mismatches == 0 && pending_results.size() == 0) begin
        $display("tb passed");
      end else begin
        $display("tb failed");
      end
    end
    $finish;
  end

endmodule
